// File: src/crc8rfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8rfc_pkg
// Shared types, codes and the CRC-8 byte step of the record frame checker.
// ----------------------------------------------------------------------------
package crc8rfc_pkg;

  localparam int MAX_PAYLOAD_DEF = 256;
  localparam int OUT_DEPTH       = 4;

  localparam logic [7:0]  CRC_POLY     = 8'h07;
  localparam logic [7:0]  CRC_INIT     = 8'h00;
  localparam logic [15:0] CAPACITY_RST = 16'd256;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MARK  = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_OVER_CAP  = 3'd4;
  localparam logic [2:0] ST_CRC_ERR   = 3'd5;

  // parser position
  localparam logic [2:0] POS_MARKER   = 3'd0;
  localparam logic [2:0] POS_VERSION  = 3'd1;
  localparam logic [2:0] POS_LEN_LO   = 3'd2;
  localparam logic [2:0] POS_LEN_HI   = 3'd3;
  localparam logic [2:0] POS_CRC      = 3'd4;
  localparam logic [2:0] POS_RSVD     = 3'd5;
  localparam logic [2:0] POS_PAYLOAD  = 3'd6;

  // register indexes
  localparam logic [1:0] REG_MARKER   = 2'd0;
  localparam logic [1:0] REG_VERSION  = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  typedef struct packed {
    logic [7:0]  marker_value;
    logic [7:0]  format_version;
    logic [15:0] out_capacity;
  } cfg_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       verdict_valid;
    logic [2:0] status;
    logic [8:0] record_length;
    logic       end_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: src/crc8rfc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8rfc_cfg_regs
// APB register file: marker, format version and consumer capacity.
// ----------------------------------------------------------------------------
module crc8rfc_cfg_regs
  import crc8rfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker_value   <= 8'h00;
      cfg_q.format_version <= 8'h00;
      cfg_q.out_capacity   <= CAPACITY_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MARKER:   cfg_q.marker_value   <= pwdata[7:0];
        REG_VERSION:  cfg_q.format_version <= pwdata[7:0];
        REG_CAPACITY: cfg_q.out_capacity   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MARKER:   prdata = {24'h0, cfg_q.marker_value};
      REG_VERSION:  prdata = {24'h0, cfg_q.format_version};
      REG_CAPACITY: prdata = {16'h0, cfg_q.out_capacity};
      default:      prdata = 32'h0;
    endcase
  end

endmodule

// File: src/crc8rfc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8rfc_parser
// Header parse, checks and payload CRC; up to two results per byte.
// ----------------------------------------------------------------------------
module crc8rfc_parser
  import crc8rfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       sor_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output push_t      push_o
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [2:0]    pos_q, pos_d;
  logic [2:0]    err_q, err_d;
  logic          fin_q, fin_d;
  logic [7:0]    crc_q, crc_d;
  logic [15:0]   len_q, len_d;
  logic [7:0]    hcrc_q, hcrc_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [2:0]    pos_e, err_e, hdr_err;
  logic [7:0]    crc_n;
  logic [CW-1:0] cnt_n;
  logic          last;
  result_t       none;

  always_comb begin
    none = '0;
    pos_e = sor_i ? POS_MARKER : pos_q;
    err_e = sor_i ? ST_OK : err_q;
    crc_n = crc8_byte(crc_q, byte_i);
    cnt_n = cnt_q + CW'(1);
    last  = 16'(cnt_n) >= len_q;

    hdr_err = err_e;
    if (hdr_err == ST_OK && (len_q == 16'd0 || len_q > 16'(MAX_PAYLOAD))) begin
      hdr_err = ST_BAD_LEN;
    end
    if (hdr_err == ST_OK && len_q > cfg_i.out_capacity) begin
      hdr_err = ST_OVER_CAP;
    end

    pos_d  = pos_q;
    err_d  = err_q;
    fin_d  = fin_q;
    crc_d  = crc_q;
    len_d  = len_q;
    hcrc_d = hcrc_q;
    cnt_d  = cnt_q;
    push_o = '{count: 2'd0, res0: none, res1: none};

    if (accept_i && (sor_i || !fin_q)) begin
      fin_d = 1'b0;
      err_d = err_e;
      pos_d = (pos_e == POS_PAYLOAD) ? POS_PAYLOAD : pos_e + 3'd1;
      case (pos_e)
        POS_MARKER: begin
          err_d = (byte_i != cfg_i.marker_value) ? ST_BAD_MARK : ST_OK;
        end
        POS_VERSION: begin
          if (err_e == ST_OK && byte_i != cfg_i.format_version) err_d = ST_BAD_VER;
        end
        POS_LEN_LO: len_d = {8'h00, byte_i};
        POS_LEN_HI: len_d = {byte_i, len_q[7:0]};
        POS_CRC:    hcrc_d = byte_i;
        POS_RSVD: begin
          crc_d = CRC_INIT;
          cnt_d = '0;
          if (hdr_err != ST_OK) begin
            fin_d = 1'b1;
            push_o.count = 2'd1;
            push_o.res0.verdict_valid = 1'b1;
            push_o.res0.status        = hdr_err;
            push_o.res0.end_of_run    = 1'b1;
          end
        end
        default: begin
          crc_d = crc_n;
          cnt_d = cnt_n;
          push_o.res0.payload_valid = 1'b1;
          push_o.res0.payload_byte  = byte_i;
          push_o.res0.end_of_run    = !last;
          push_o.count = 2'd1;
          if (last) begin
            fin_d = 1'b1;
            push_o.count = 2'd2;
            push_o.res1.verdict_valid = 1'b1;
            push_o.res1.status        = (crc_n == hcrc_q) ? ST_OK : ST_CRC_ERR;
            push_o.res1.record_length = (crc_n == hcrc_q) ? len_q[8:0] : 9'd0;
            push_o.res1.end_of_run    = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_MARKER;
      err_q  <= ST_OK;
      fin_q  <= 1'b1;
      crc_q  <= CRC_INIT;
      len_q  <= 16'h0;
      hcrc_q <= 8'h00;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      err_q  <= err_d;
      fin_q  <= fin_d;
      crc_q  <= crc_d;
      len_q  <= len_d;
      hcrc_q <= hcrc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: src/crc8rfc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8rfc_out_fifo
// Result queue: takes up to two results a cycle, hands out one while ready_i is high.
// ----------------------------------------------------------------------------
module crc8rfc_out_fifo
  import crc8rfc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t head_o
);

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int NW = $clog2(OUT_DEPTH + 1);

  result_t       mem [OUT_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          pop;

  assign valid_o = cnt_q != '0;
  assign head_o  = mem[rd_q];
  assign pop     = valid_o & ready_i;
  assign room_o  = cnt_q <= NW'(OUT_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem[wr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem[wr_q + PW'(1)] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(push_i.count);
      rd_q  <= rd_q + PW'(pop);
      cnt_q <= cnt_q + NW'(push_i.count) - NW'(pop);
    end
  end

endmodule

// File: src/crc8_record_frame_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_record_frame_checker_unit
// Length-framed record checker with CRC-8 (poly 0x07) over the payload.
//
// channel   dir  tdata                 tuser                          tlast
// s_axis    in   stored_byte           start_of_record                -
// m_axis    out  byte/status/length    payload_valid, verdict_valid   end_of_run
// apb       in   regs 0x0 marker, 0x4 version, 0x8 capacity
//
// One byte accepted per cycle while s_axis_tready is high; each byte is parsed in the cycle it is taken.
// The last payload byte yields two results; the 4-entry result queue drains
// one per cycle while m_axis_tready is high.
// s_axis_tready drops only while the queue lacks room for two results.
// Reset: parser idles until a start byte; no clearing pass.
// ----------------------------------------------------------------------------
module crc8_record_frame_checker_unit
  import crc8rfc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stored_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_of_record
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                      // [19:11] record_length, [23:20] zero
  output logic [1:0]  m_axis_tuser,   // [0] payload_valid, [1] verdict_valid
  output logic        m_axis_tlast,   // end_of_run
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  push_t   push;
  result_t head;
  logic    room;

  assign s_axis_tready = room;

  crc8rfc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  crc8rfc_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk_i, .rst_ni,
    .accept_i(s_axis_tvalid & s_axis_tready),
    .sor_i(s_axis_tuser[0]),
    .byte_i(s_axis_tdata),
    .cfg_i(cfg),
    .push_o(push)
  );

  crc8rfc_out_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push),
    .room_o(room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .head_o(head)
  );

  assign m_axis_tdata = {4'h0, head.record_length, head.status, head.payload_byte};
  assign m_axis_tuser = {head.verdict_valid, head.payload_valid};
  assign m_axis_tlast = head.end_of_run;

endmodule

// File: src/crc8rfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8rfc_checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module crc8rfc_checker
  import crc8rfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result transaction changed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tuser))
    else $error("result is neither payload nor verdict, or both");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("verdict without end of run");

  a_fail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] && m_axis_tdata[10:8] != ST_OK
      |-> m_axis_tdata[19:11] == 9'd0 && m_axis_tdata[7:0] == 8'd0)
    else $error("failed verdict carries a length or byte");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:8] == 16'd0)
    else $error("payload result carries status or length");

endmodule

bind crc8_record_frame_checker_unit crc8rfc_checker u_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
  .m_axis_tlast
);

// File: dv/crc8_record_frame_checker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_record_frame_checker_unit_tb
// Self-checking bench for the record frame checker. Records are streamed
// byte by byte with random gaps and back-pressure. Each phase uses different
// register settings and mixes well-formed records with broken headers,
// CRC errors, restarts and ignored bytes. Each output transaction is compared
// in order against a model of the parser that is kept in the scoreboard.
// ----------------------------------------------------------------------------
module crc8_record_frame_checker_unit_tb;
  import crc8rfc_pkg::*;

  localparam int          MAXP         = MAX_PAYLOAD_DEF;
  localparam int unsigned HDR_BYTES    = POS_PAYLOAD;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam longint      TIMEOUT_NS   = 20_000_000;

  class record_scoreboard;
    logic [7:0]  marker_q;
    logic [7:0]  version_q;
    logic [15:0] capacity_q;
    int unsigned byte_idx;
    logic [7:0]  crc_acc;
    logic [7:0]  crc_hdr;
    logic [15:0] len_hdr;
    logic [2:0]  hdr_err;
    bit          idle;
    result_t     expected_q[$];
    int unsigned mismatches;

    function new();
      marker_q   = '0;
      version_q  = '0;
      capacity_q = CAPACITY_RST;
      byte_idx   = 0;
      crc_acc    = CRC_INIT;
      crc_hdr    = '0;
      len_hdr    = '0;
      hdr_err    = ST_OK;
      idle       = 1'b1;
      mismatches = 0;
    endfunction

    static function logic [7:0] crc_update(logic [7:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ d[i];
        c  = {c[6:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function result_t make_result(bit pv, logic [7:0] pb, bit vv, logic [2:0] st,
                                  logic [8:0] len, bit eor);
      result_t r;
      r.payload_valid = pv;
      r.payload_byte  = pb;
      r.verdict_valid = vv;
      r.status        = st;
      r.record_length = len;
      r.end_of_run    = eor;
      return r;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MARKER:   marker_q   = val[7:0];
        REG_VERSION:  version_q  = val[7:0];
        REG_CAPACITY: capacity_q = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_byte(bit sor, logic [7:0] b);
      logic [2:0] err;
      bit         crc_ok;
      if (sor) begin
        byte_idx = 0;
        crc_acc  = CRC_INIT;
        len_hdr  = '0;
        crc_hdr  = '0;
        hdr_err  = ST_OK;
        idle     = 1'b0;
      end else if (idle) begin
        return;
      end
      if (byte_idx < HDR_BYTES) begin
        case (byte_idx)
          POS_MARKER:  if (b != marker_q) hdr_err = ST_BAD_MARK;
          POS_VERSION: if (hdr_err == ST_OK && b != version_q) hdr_err = ST_BAD_VER;
          POS_LEN_LO:  len_hdr[7:0] = b;
          POS_LEN_HI:  len_hdr[15:8] = b;
          POS_CRC:     crc_hdr = b;
          default: begin
            err = hdr_err;
            if (err == ST_OK && (len_hdr == 0 || len_hdr > MAXP)) err = ST_BAD_LEN;
            if (err == ST_OK && len_hdr > capacity_q) err = ST_OVER_CAP;
            if (err != ST_OK) begin
              idle = 1'b1;
              expected_q.push_back(make_result(1'b0, 8'h00, 1'b1, err, 9'd0, 1'b1));
            end
          end
        endcase
        byte_idx++;
        return;
      end
      crc_acc = crc_update(crc_acc, b);
      byte_idx++;
      if (byte_idx - HDR_BYTES >= len_hdr) begin
        crc_ok = (crc_acc == crc_hdr);
        idle   = 1'b1;
        expected_q.push_back(make_result(1'b1, b, 1'b0, ST_OK, 9'd0, 1'b0));
        expected_q.push_back(make_result(1'b0, 8'h00, 1'b1, crc_ok ? ST_OK : ST_CRC_ERR,
                                         crc_ok ? len_hdr[8:0] : 9'd0, 1'b1));
      end else begin
        expected_q.push_back(make_result(1'b1, b, 1'b0, ST_OK, 9'd0, 1'b1));
      end
    endfunction

    function string show(result_t r);
      return $sformatf("pv=%0d byte=%02h vv=%0d st=%0d len=%0d eor=%0d", r.payload_valid,
                       r.payload_byte, r.verdict_valid, r.status, r.record_length,
                       r.end_of_run);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] unexpected transaction: %s", $realtime, show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte ||
          got.verdict_valid !== want.verdict_valid || got.status !== want.status ||
          got.record_length !== want.record_length || got.end_of_run !== want.end_of_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch: expected %s", $realtime, show(want));
          $display("[%0t]           actual   %s", $realtime, show(got));
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  record_scoreboard sb = new();
  bit               calm;
  bit               long_hold;
  int unsigned      items_sent;
  result_t          seen;

  crc8_record_frame_checker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned idle_gap();
    if (calm || $urandom_range(0, 99) >= 30) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // output transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.payload_valid = m_axis_tuser[0];
      seen.payload_byte  = m_axis_tdata[7:0];
      seen.verdict_valid = m_axis_tuser[1];
      seen.status        = m_axis_tdata[10:8];
      seen.record_length = m_axis_tdata[19:11];
      seen.end_of_run    = m_axis_tlast;
      sb.check_result(seen);
    end
  end

  // receiver back-pressure
  initial begin
    int unsigned gap;
    int unsigned hold_count;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        hold_count = 0;
        while (hold_count < LONG_HOLD) begin
          @(posedge clk_i);
          hold_count++;
        end
        long_hold = 1'b0;
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(bit sor, logic [7:0] b);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sor;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(sor, b);
  endtask

  task automatic send_ignored(int unsigned n);
    repeat (n) send_byte(1'b0, 8'($urandom));
  endtask

  // keep = 0 sends the whole record, fill < 0 gives a random payload
  task automatic send_record(logic [7:0] mk, logic [7:0] ver, logic [15:0] len, bit bad_crc,
                             int unsigned plen, int unsigned keep = 0, int fill = -1);
    logic [7:0]  rec[$];
    logic [7:0]  pay[$];
    logic [7:0]  crc;
    int unsigned total;
    int unsigned i;
    crc = CRC_INIT;
    for (i = 0; i < plen; i++) begin
      pay.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      crc = record_scoreboard::crc_update(crc, pay[i]);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    rec = {mk, ver, len[7:0], len[15:8], crc, 8'($urandom)};
    rec = {rec, pay};
    total = (keep == 0 || keep > rec.size()) ? rec.size() : keep;
    for (i = 0; i < total; i++) send_byte(i == 0, rec[i]);
    items_sent += total;
  endtask

  task automatic random_records(int unsigned n);
    int unsigned first;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  mk;
    logic [7:0]  ver;
    first = items_sent;
    while (items_sent - first < n) begin
      pick = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      mk   = sb.marker_q;
      ver  = sb.version_q;
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAXP) : $urandom_range(1, 16);
      if (sb.capacity_q != 0 && len > sb.capacity_q) len = $urandom_range(1, sb.capacity_q);
      if (pick < 62)
        send_record(mk, ver, 16'(len), $urandom_range(0, 9) == 0, len);
      else if (pick < 68)
        send_record(mk ^ 8'($urandom_range(1, 255)), ver, 16'(len), 0, 0);
      else if (pick < 74)
        send_record(mk, ver ^ 8'($urandom_range(1, 255)), 16'(len), 0, 0);
      else if (pick < 80)
        send_record(mk, ver, $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(MAXP + 1, 65535)),
                    0, 0);
      else if (pick < 86 && sb.capacity_q < MAXP)
        send_record(mk, ver, 16'($urandom_range(sb.capacity_q + 1, MAXP)), 0, 0);
      else if (pick < 94)
        send_record(mk, ver, 16'(len), 0, len, $urandom_range(1, len + HDR_BYTES - 1));
      else
        send_record(8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 8));
      if ($urandom_range(0, 9) == 0) send_ignored($urandom_range(1, 3));
    end
    calm = 1'b0;
  endtask

  // ends on a failed header so the parser is idle before any register write
  task automatic close_phase();
    send_record(~sb.marker_q, 8'h00, 16'd0, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    calm          = 1'b0;
    long_hold     = 1'b0;
    items_sent    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: idle bytes, ok, crc error, bad marker, restart, bad version
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_record(8'h00, 8'h00, 16'd1, 0, 1, 0, 8'hFF);
    send_record(8'h00, 8'h00, 16'd1, 1, 1, 0, 8'h00);
    send_record(8'hFF, 8'h00, 16'd1, 0, 0);
    send_record(8'h00, 8'h00, 16'd8, 0, 8, 3);
    send_record(8'h00, 8'h80, 16'd1, 0, 0);
    random_records(400);
    close_phase();

    apb_write(REG_MARKER, 32'hFF);
    apb_write(REG_VERSION, 32'hFF);
    apb_write(REG_CAPACITY, 32'h0);
    send_record(8'hFF, 8'hFF, 16'd1, 0, 0);
    send_record(8'hFF, 8'hFF, 16'd0, 0, 0);
    send_record(8'hFF, 8'hFF, 16'hFFFF, 0, 0);
    random_records(200);
    close_phase();

    apb_write(REG_MARKER, $urandom_range(0, 255));
    apb_write(REG_VERSION, $urandom_range(0, 255));
    apb_write(REG_CAPACITY, 32'd16);
    send_record(sb.marker_q, sb.version_q, 16'd16, 0, 16);
    send_record(sb.marker_q, sb.version_q, 16'd17, 0, 0);
    long_hold = 1'b1;
    random_records(400);
    close_phase();

    apb_write(REG_MARKER, 32'h5A);
    apb_write(REG_VERSION, 32'hA5);
    apb_write(REG_CAPACITY, 32'hFFFF);
    send_record(8'h5A, 8'hA5, 16'd256, 0, 256);
    send_record(8'h5A, 8'hA5, 16'd257, 0, 0);
    random_records(300);
    close_phase();

    apb_write(REG_MARKER, 32'hA5);
    apb_write(REG_VERSION, 32'h5A);
    apb_write(REG_CAPACITY, 32'd255);
    send_record(8'hA5, 8'h5A, 16'd256, 0, 0);
    random_records(200);
    close_phase();

    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
